FILE: rtl/lattice_multilinear_interpolator_top_assert.svh
// Assertion macros shared by the lattice interpolator modules.
`ifndef LATTICE_MULTILINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define LATTICE_MULTILINEAR_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on clk and disabled while rst_n is low
`define LMI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmi: implication check failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low
`define LMI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmi: next-cycle check failed");

`else

`define LMI_ASSERT_IMP(label, ante, cons)
`define LMI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/lmi_pkg.sv
// Types and constants shared by the lattice interpolator modules.
`timescale 1ns / 1ps

package lmi_pkg;

    // Port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_COORDS  = 4;

    // Internal widths sized for the full dimension range (up to four axes)
    localparam int AXIS_W   = 2;
    localparam int CORNER_W = 4;
    localparam int SIZE_W   = 25;   // (63 + 1)^4 fits
    localparam int PROD_W   = 49;   // 32-bit value times weight up to 2^16
    localparam int ACC_W    = 53;   // sixteen products

    // Configuration register reset values
    localparam logic [2:0] DIMS_RESET = 3'd2;
    localparam logic [5:0] DIVS_RESET = 6'd4;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIMS_IN_USE = 2'd0,
        CFG_DIVISIONS   = 2'd1
    } cfg_reg_t;

    // Request operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Request payload
    typedef struct packed {
        logic               operation;
        logic [11:0]        entry_index;
        logic signed [31:0] entry_value;
        logic [16:0]        coord_0;
        logic [16:0]        coord_1;
        logic [16:0]        coord_2;
        logic [16:0]        coord_3;
    } req_t;

    // Result payload
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               range_error;
    } res_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_WRITE,
        DP_AXES,
        DP_SIZE,
        DP_OVER,
        DP_READ,
        DP_WEIGHT,
        DP_MULT,
        DP_ACC,
        DP_ROUND,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                op;
        logic [AXIS_W-1:0]     axis;
        logic [CORNER_W-1:0]   corner;
    } dp_cmd_t;

    typedef struct packed {
        logic       is_write;
        logic       size_over;
        logic       out_free;
        logic [2:0] n_eff;
    } dp_status_t;

endpackage

FILE: rtl/lmi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/lmi_datapath.sv
// Lattice interpolator datapath: config registers, axis cells, weights, accumulator.
`timescale 1ns / 1ps
`include "lattice_multilinear_interpolator_top_assert.svh"

module lmi_datapath
    import lmi_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_DIMS    = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  req_t                   req_data,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_t                   res_data
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int AXW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef struct packed {
        logic [6:0]  lo;
        logic [16:0] wlo;
        logic [16:0] whi;
    } axis_t;

    // Cell bounds and weights for one axis
    function automatic axis_t split_axis(input logic [16:0] x, input logic [5:0] t);
        logic [16:0] xs;
        logic [22:0] u;
        logic [6:0]  lo;
        logic [6:0]  hi;
        axis_t       r;
        xs = (x > 17'd65536) ? 17'd65536 : x;
        u  = 23'(xs * t);
        lo = u[22:16];
        hi = lo + 7'(u[15:0] != 16'd0);
        // on a grid line: widen toward the interior
        if (lo == hi)
        begin
            if (lo == 7'd0)
                hi = 7'd1;
            else
                lo = lo - 7'd1;
        end
        r.lo  = lo;
        r.wlo = 17'({hi, 16'd0} - u);
        r.whi = 17'(u - {lo, 16'd0});
        return r;
    endfunction

    // Config and control registers
    logic [2:0] dims_reg;
    logic [5:0] divs_reg;
    logic       res_valid_reg;

    // Payload registers
    req_t                     req_reg;
    logic [6:0]               lo_reg     [MAX_DIMS];
    logic [16:0]              wlo_reg    [MAX_DIMS];
    logic [16:0]              whi_reg    [MAX_DIMS];
    logic [SIZE_W-1:0]        stride_reg [MAX_DIMS];
    logic [SIZE_W-1:0]        size_reg;
    logic [SIZE_W-1:0]        base_reg;
    logic [16:0]              w_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    res_t                     fin_reg;
    res_t                     res_data_reg;

    logic [2:0]        n_eff;
    logic [5:0]        t_eff;
    logic [6:0]        tp1;
    logic [16:0]       coord [NUM_COORDS];
    axis_t             split [MAX_DIMS];
    logic [SIZE_W-1:0] addr_sum;
    logic [AXW-1:0]    ax;
    logic [16:0]       wsel;
    logic [33:0]       wprod;
    logic [16:0]       w_next;
    logic [16:0]       w_first;
    logic              idx_in_range;
    logic [31:0]       rd_data;
    logic signed [ACC_W-1:0] rsum;
    logic signed [ACC_W-1:0] rshift;
    logic [31:0]       rsat;

    // Effective dimensions and divisions
    always_comb
    begin
        if (dims_reg == 3'd0)
            n_eff = 3'd1;
        else if (32'(dims_reg) > 32'(MAX_DIMS))
            n_eff = 3'(MAX_DIMS);
        else
            n_eff = dims_reg;
        t_eff = (divs_reg == 6'd0) ? 6'd1 : divs_reg;
        tp1   = {1'b0, t_eff} + 7'd1;
    end

    assign coord[0] = req_reg.coord_0;
    assign coord[1] = req_reg.coord_1;
    assign coord[2] = req_reg.coord_2;
    assign coord[3] = req_reg.coord_3;

    // Per-axis cells, all axes in parallel
    always_comb
    begin
        for (int j = 0; j < MAX_DIMS; j++)
        begin
            split[j] = split_axis(coord[j], t_eff);
        end
    end

    // Corner address: low corner base plus the strides of axes taken high
    always_comb
    begin
        addr_sum = base_reg;
        for (int j = 0; j < MAX_DIMS; j++)
        begin
            if ((32'(j) < 32'(n_eff)) && !cmd.corner[j])
                addr_sum = addr_sum + stride_reg[j];
        end
    end

    // Weight product step, rounded half up back to Q0.16
    always_comb
    begin
        ax      = cmd.axis[AXW-1:0];
        wsel    = cmd.corner[ax] ? wlo_reg[ax] : whi_reg[ax];
        wprod   = 34'(w_reg * wsel) + 34'd32768;
        w_next  = wprod[32:16];
        w_first = cmd.corner[0] ? wlo_reg[0] : whi_reg[0];
    end

    assign idx_in_range = 32'(req_reg.entry_index) < 32'(TABLE_DEPTH);

    // Final rounding and saturation
    always_comb
    begin
        rsum   = acc_reg + ACC_W'(32768);
        rshift = rsum >>> 16;
        if ((rshift[ACC_W-1:31] == '0) || (rshift[ACC_W-1:31] == '1))
            rsat = rshift[31:0];
        else if (rshift[ACC_W-1])
            rsat = 32'h8000_0000;
        else
            rsat = 32'h7FFF_FFFF;
    end

    lmi_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_lattice_ram (
        .clk     (clk),
        .wr_en   ((cmd.op == DP_WRITE) && idx_in_range),
        .wr_addr (AW'(req_reg.entry_index)),
        .wr_data (req_reg.entry_value),
        .rd_en   (cmd.op == DP_READ),
        .rd_addr (AW'(addr_sum)),
        .rd_data (rd_data)
    );

    // Config registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg      <= DIMS_RESET;
            divs_reg      <= DIVS_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_DIMS_IN_USE: dims_reg <= cfg_data[2:0];
                    CFG_DIVISIONS:   divs_reg <= cfg_data[5:0];
                    default:         ;
                endcase
            end
            if (cmd.op == DP_OUT)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Arithmetic and payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LATCH:
            begin
                req_reg <= req_data;
            end
            DP_WRITE:
            begin
                fin_reg.result_value <= '0;
                fin_reg.range_error  <= !idx_in_range;
            end
            DP_AXES:
            begin
                for (int j = 0; j < MAX_DIMS; j++)
                begin
                    lo_reg[j]  <= split[j].lo;
                    wlo_reg[j] <= split[j].wlo;
                    whi_reg[j] <= split[j].whi;
                end
                size_reg <= SIZE_W'(1);
                base_reg <= '0;
                acc_reg  <= '0;
            end
            DP_SIZE:
            begin
                // strides are built from the last axis toward axis 0
                stride_reg[ax] <= size_reg;
                base_reg       <= base_reg + SIZE_W'(lo_reg[ax] * size_reg);
                size_reg       <= SIZE_W'(size_reg * tp1);
            end
            DP_OVER:
            begin
                fin_reg.result_value <= '0;
                fin_reg.range_error  <= 1'b1;
            end
            DP_READ:
            begin
                w_reg <= w_first;
            end
            DP_WEIGHT:
            begin
                w_reg <= w_next;
            end
            DP_MULT:
            begin
                prod_reg <= PROD_W'($signed(rd_data)) * PROD_W'($signed({1'b0, w_reg}));
            end
            DP_ACC:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            DP_ROUND:
            begin
                fin_reg.result_value <= rsat;
                fin_reg.range_error  <= 1'b0;
            end
            DP_OUT:
            begin
                res_data_reg <= fin_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready        = 1'b1;
    assign res_valid        = res_valid_reg;
    assign res_data         = res_data_reg;
    assign status.is_write  = (req_reg.operation == OP_WRITE);
    assign status.size_over = 32'(size_reg) > 32'(TABLE_DEPTH);
    assign status.out_free  = !res_valid_reg || !res_stall;
    assign status.n_eff     = n_eff;

    `LMI_ASSERT_IMP(a_out_slot_free, cmd.op == DP_OUT, !res_valid_reg || !res_stall)
    `LMI_ASSERT_IMP(a_corner_in_lattice, cmd.op == DP_READ, addr_sum < size_reg)
    `LMI_ASSERT_NEXT(a_valid_held, res_valid_reg && res_stall, res_valid_reg)
    `LMI_ASSERT_NEXT(a_data_held, res_valid_reg && res_stall, $stable(res_data_reg))

endmodule

FILE: rtl/lmi_ctrl.sv
// Lattice interpolator controller: sequences setup, corner loop and result hand-off.
`timescale 1ns / 1ps
`include "lattice_multilinear_interpolator_top_assert.svh"

module lmi_ctrl
    import lmi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SIZE,
        S_CHECK,
        S_READ,
        S_WEIGHT,
        S_MULT,
        S_ACC,
        S_ROUND,
        S_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [AXIS_W-1:0]   axis_reg;
    logic [AXIS_W-1:0]   axis_next;
    logic [CORNER_W-1:0] corner_reg;
    logic [CORNER_W-1:0] corner_next;
    logic [AXIS_W-1:0]   last_axis;
    logic [CORNER_W-1:0] last_corner;

    assign last_axis   = AXIS_W'(status.n_eff - 3'd1);
    assign last_corner = CORNER_W'((5'd1 << status.n_eff) - 5'd1);

    // Next state and datapath command
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        corner_next = corner_reg;
        cmd.op      = DP_NOP;
        cmd.axis    = axis_reg;
        cmd.corner  = corner_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_write)
                begin
                    cmd.op     = DP_WRITE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = DP_AXES;
                    axis_next  = last_axis;
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                cmd.op = DP_SIZE;
                if (axis_reg == '0)
                    state_next = S_CHECK;
                else
                    axis_next = axis_reg - AXIS_W'(1);
            end
            S_CHECK:
            begin
                if (status.size_over)
                begin
                    cmd.op     = DP_OVER;
                    state_next = S_DONE;
                end
                else
                begin
                    corner_next = '0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.op = DP_READ;
                if (last_axis == '0)
                begin
                    state_next = S_MULT;
                end
                else
                begin
                    axis_next  = AXIS_W'(1);
                    state_next = S_WEIGHT;
                end
            end
            S_WEIGHT:
            begin
                cmd.op = DP_WEIGHT;
                if (axis_reg == last_axis)
                    state_next = S_MULT;
                else
                    axis_next = axis_reg + AXIS_W'(1);
            end
            S_MULT:
            begin
                cmd.op     = DP_MULT;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = DP_ACC;
                if (corner_reg == last_corner)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    corner_next = corner_reg + CORNER_W'(1);
                    state_next  = S_READ;
                end
            end
            S_ROUND:
            begin
                cmd.op     = DP_ROUND;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            axis_reg   <= '0;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            corner_reg <= corner_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    `LMI_ASSERT_NEXT(a_accept_to_decode, req_valid && !req_stall, state_reg == S_DECODE)
    `LMI_ASSERT_IMP(a_weight_axis_nonzero, state_reg == S_WEIGHT, axis_reg != '0)
    `LMI_ASSERT_IMP(a_weight_axis_range, state_reg == S_WEIGHT, 3'(axis_reg) < status.n_eff)
    `LMI_ASSERT_IMP(a_corner_range, state_reg == S_READ, corner_reg <= last_corner)

endmodule

FILE: rtl/lattice_multilinear_interpolator_top.sv
// Multilinear lattice interpolator: ports, controller and datapath.
`timescale 1ns / 1ps

// One request at a time. A write request stores one lattice value and its result
// is ready once the done state moves it to the output register. For n dimensions
// in use a query builds the axis strides and lattice size axis by axis, then each
// of the 2^n corners takes one table read, n - 1 weight products through the
// single 17x17 multiplier, one value-times-weight product and one accumulate. The
// single read port of the lattice RAM and that shared weight multiplier set the
// per-corner cost. The result sits in an output register, so a new request is
// accepted as soon as the previous result has been moved there, even while it
// waits on res_stall. Lattice entries hold no defined value until written.
// Configuration is written through cfg_valid/cfg_index/cfg_data while the block
// is idle. The block itself does not enforce this.
module lattice_multilinear_interpolator_top
    import lmi_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_DIMS    = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_t                   res_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    lmi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, lattice storage and result register
    lmi_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_DIMS    (MAX_DIMS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

FILE: test/tb_lattice_multilinear_interpolator_top.sv
// Self-checking testbench for the lattice multilinear interpolator top level.
`timescale 1ns / 1ps

module tb_lattice_multilinear_interpolator_top;
    import lmi_pkg::*;

    localparam int LATTICE_DEPTH = 4096;
    localparam int AXES_MAX = 4;
    // A four-axis query, the longest gap on each side and the long result hold
    // together still stay far below this in a correct run.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int MAX_REPORTS = 30;
    localparam int RANDOM_OPS_PER_PHASE = 25;
    localparam int PHASES = 14;
    // Register indexes past the two defined ones; writes there change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic [16:0] COORD_ONE = 17'd65536;
    // Fixed lattice shapes: smallest, too large for the table, zero register
    // values, axes past the limit, the three shapes that exactly fill the
    // table, then a few ordinary ones. Random shapes follow.
    localparam int SHAPE_DIMS [10] = '{1, 4, 0, 7, 3, 4, 2, 1, 3, 2};
    localparam int SHAPE_DIVS [10] = '{1, 63, 0, 2, 15, 7, 63, 63, 3, 1};

    // Tracks lattice contents and registers and predicts every result
    class lattice_scoreboard;
        logic signed [31:0] lattice [LATTICE_DEPTH];
        logic [2:0] dims_reg;
        logic [5:0] divs_reg;
        res_t expected_results [$];
        longint unsigned cell_lo [AXES_MAX];
        longint unsigned cell_hi [AXES_MAX];
        longint unsigned weight_lo [AXES_MAX];
        longint unsigned weight_hi [AXES_MAX];
        int mismatches;
        int writes_seen;
        int queries_seen;
        int range_errors;
        int saturations;

        function new();
            dims_reg = DIMS_RESET;
            divs_reg = DIVS_RESET;
            foreach (lattice[i])
                lattice[i] = '0;
            mismatches = 0;
            writes_seen = 0;
            queries_seen = 0;
            range_errors = 0;
            saturations = 0;
        endfunction

        function int axis_count();
            if (dims_reg == 3'd0)
                return 1;
            if (dims_reg > AXES_MAX)
                return AXES_MAX;
            return int'(dims_reg);
        endfunction

        function int grid_divs();
            return (divs_reg == 6'd0) ? 1 : int'(divs_reg);
        endfunction

        function int lattice_points();
            int points;
            points = 1;
            for (int j = 0; j < axis_count(); j++)
                points = points * (grid_divs() + 1);
            return points;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DIMS_IN_USE)
                dims_reg = data[2:0];
            else if (idx == CFG_DIVISIONS)
                divs_reg = data[5:0];
        endfunction

        // Finds the enclosing cell and its weights on every axis. Returns the
        // number of corners, or zero when the lattice does not fit the table.
        function int find_cell(input req_t r);
            int n;
            longint unsigned t;
            longint unsigned x;
            longint unsigned u;
            logic [16:0] coords [AXES_MAX];
            n = axis_count();
            t = longint'(grid_divs());
            if (lattice_points() > LATTICE_DEPTH)
                return 0;
            coords[0] = r.coord_0;
            coords[1] = r.coord_1;
            coords[2] = r.coord_2;
            coords[3] = r.coord_3;
            for (int j = 0; j < n; j++)
            begin
                x = (coords[j] > COORD_ONE) ? COORD_ONE : coords[j];
                u = x * t;
                cell_lo[j] = u >> 16;
                cell_hi[j] = (u + 65535) >> 16;
                // a point on a grid line takes the cell toward the interior
                if (cell_lo[j] == cell_hi[j])
                begin
                    if (cell_lo[j] == 0)
                        cell_hi[j] = 1;
                    else
                        cell_lo[j] = cell_lo[j] - 1;
                end
                weight_lo[j] = (cell_hi[j] << 16) - u;
                weight_hi[j] = u - (cell_lo[j] << 16);
            end
            return 1 << n;
        endfunction

        // A set bit j in the corner number picks the low end of axis j
        function int corner_index(input int c);
            longint unsigned idx;
            longint unsigned t;
            idx = 0;
            t = longint'(grid_divs());
            for (int j = 0; j < axis_count(); j++)
                idx = idx * (t + 1) + (c[j] ? cell_lo[j] : cell_hi[j]);
            return int'(idx);
        endfunction

        // Product of axis weights, kept in Q0.16 with round half up per step
        function longint unsigned corner_weight(input int c);
            longint unsigned w;
            longint unsigned wj;
            w = 0;
            for (int j = 0; j < axis_count(); j++)
            begin
                wj = c[j] ? weight_lo[j] : weight_hi[j];
                w = (j == 0) ? wj : ((w * wj + 32768) >> 16);
            end
            return w;
        endfunction

        function res_t interpolate(input req_t r);
            res_t outcome;
            int corners;
            longint acc;
            longint rounded;
            outcome = '0;
            corners = find_cell(r);
            if (corners == 0)
            begin
                outcome.range_error = 1'b1;
                return outcome;
            end
            acc = 0;
            for (int c = 0; c < corners; c++)
                acc += longint'(lattice[corner_index(c)]) * longint'(corner_weight(c));
            // Q.32 sum back to Q16.16, round half up, then clamp
            rounded = (acc + 32768) >>> 16;
            if (rounded > longint'(VALUE_MAX))
            begin
                rounded = longint'(VALUE_MAX);
                saturations++;
            end
            else if (rounded < longint'(VALUE_MIN))
            begin
                rounded = longint'(VALUE_MIN);
                saturations++;
            end
            outcome.result_value = rounded[31:0];
            return outcome;
        endfunction

        function void note_request(input req_t r);
            res_t outcome;
            if (r.operation == OP_WRITE)
            begin
                lattice[r.entry_index] = r.entry_value;
                outcome = '0;
                writes_seen++;
            end
            else
            begin
                outcome = interpolate(r);
                queries_seen++;
                if (outcome.range_error)
                    range_errors++;
            end
            expected_results = {expected_results, outcome};
        endfunction

        function void check_result(input res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got value %0d error %0b",
                             $time, got.result_value, got.range_error);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.result_value !== want.result_value)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result_value expected %0d, got %0d",
                             $time, want.result_value, got.result_value);
                mismatches++;
            end
            if (got.range_error !== want.range_error)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: range_error expected %0b, got %0b",
                             $time, want.range_error, got.range_error);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    lattice_scoreboard lattice_check;
    bit entry_written [LATTICE_DEPTH];
    bit steady_flow = 1'b0;
    int pressure_asked = 0;
    int pressure_done = 0;
    int idle_cycles = 0;
    int settings_used = 0;

    lattice_multilinear_interpolator_top #(
        .TABLE_DEPTH(LATTICE_DEPTH),
        .MAX_DIMS(AXES_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data(res_data)
    );

    // 8 ns clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Handshake monitor: feeds the scoreboard and watches for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                lattice_check.set_register(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                lattice_check.note_request(req_data);
            if (res_valid && !res_stall)
                lattice_check.check_result(res_data);
            if ((cfg_valid && cfg_ready) || (req_valid && !req_stall) ||
                (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Mostly short idles, now and then a long one; none in steady phases
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 90);
    endfunction

    // Result side: random stalls, plus a long hold whenever one is asked for
    initial
    begin : result_sink
        int hold;
        int run;
        forever
        begin
            @(negedge clk);
            if (pressure_asked != pressure_done)
            begin
                res_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(negedge clk);
                res_stall <= 1'b0;
                pressure_done++;
            end
            else
            begin
                hold = idle_length();
                if (hold > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                end
                res_stall <= 1'b0;
                run = $urandom_range(1, 12);
                repeat (run - 1) @(negedge clk);
            end
        end
    end

    function automatic req_t random_payload();
        req_t r;
        r.operation = 1'($urandom_range(0, 1));
        r.entry_index = 12'($urandom);
        r.entry_value = $urandom;
        r.coord_0 = 17'($urandom);
        r.coord_1 = 17'($urandom);
        r.coord_2 = 17'($urandom);
        r.coord_3 = 17'($urandom);
        return r;
    endfunction

    // Coordinates: ends of the range, above one, on grid lines, or anywhere
    function automatic logic [16:0] pick_coord(input int divs);
        int k;
        k = $urandom_range(0, divs);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COORD_ONE;
            2: return 17'($urandom_range(65537, 131071));
            3, 4: return 17'((k * 65536) / divs);
            5: return ($urandom_range(0, 1) != 0) ? 17'd1 : 17'd65535;
            default: return 17'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return 32'(int'($urandom_range(0, 2047)) - 1024);
            default: return $urandom;
        endcase
    endfunction

    // Drives one request and returns at the falling edge after it is taken
    task automatic send_request(input req_t r);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_write(input logic [11:0] idx, input logic signed [31:0] value);
        req_t r;
        r = random_payload();
        r.operation = OP_WRITE;
        r.entry_index = idx;
        r.entry_value = value;
        entry_written[idx] = 1'b1;
        send_request(r);
    endtask

    // Stores any corner the query reads that was never written, then queries
    task automatic send_query(input req_t q);
        int corners;
        int missing [$];
        q.operation = OP_QUERY;
        corners = lattice_check.find_cell(q);
        for (int c = 0; c < corners; c++)
            if (!entry_written[lattice_check.corner_index(c)])
                missing = {missing, lattice_check.corner_index(c)};
        foreach (missing[i])
            if (!entry_written[missing[i]])
                send_write(12'(missing[i]), pick_value());
        send_request(q);
    endtask

    task automatic query_at(input logic [16:0] c0, input logic [16:0] c1);
        req_t q;
        q = random_payload();
        q.coord_0 = c0;
        q.coord_1 = c1;
        send_query(q);
    endtask

    task automatic random_traffic(input int count);
        req_t q;
        int points;
        int index;
        int divs;
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // most writes land inside the lattice in use
                points = lattice_check.lattice_points();
                if (points <= LATTICE_DEPTH && $urandom_range(0, 2) != 0)
                    index = $urandom_range(0, points - 1);
                else
                    index = $urandom_range(0, LATTICE_DEPTH - 1);
                send_write(12'(index), pick_value());
            end
            else
            begin
                divs = lattice_check.grid_divs();
                q = random_payload();
                q.coord_0 = pick_coord(divs);
                q.coord_1 = pick_coord(divs);
                q.coord_2 = pick_coord(divs);
                q.coord_3 = pick_coord(divs);
                send_query(q);
            end
        end
    endtask

    // Lets every outstanding result drain, then a few quiet cycles
    task automatic settle();
        req_valid <= 1'b0;
        while (lattice_check.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Loads a new lattice shape once the block is idle; unused data bits random
    task automatic reshape(input int dims, input int divs, input bit spare);
        settle();
        write_register(CFG_DIMS_IN_USE, {5'($urandom), 3'(dims)});
        write_register(CFG_DIVISIONS, {2'($urandom), 6'(divs)});
        if (spare)
        begin
            write_register(CFG_SPARE_LO, 8'($urandom));
            write_register(CFG_SPARE_HI, 8'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Default shape, two axes of four divisions: full-scale cells, the
    // corners of the unit square, saturated coordinates and grid lines
    task automatic directed_checks();
        send_write(12'd0, VALUE_MAX);
        send_write(12'd1, VALUE_MAX);
        send_write(12'd5, VALUE_MAX);
        send_write(12'd6, VALUE_MAX);
        query_at('0, '0);
        query_at(17'd8192, 17'd8192);
        query_at(17'd1, 17'd1);
        send_write(12'd18, VALUE_MIN);
        send_write(12'd19, VALUE_MIN);
        send_write(12'd23, VALUE_MIN);
        send_write(12'd24, VALUE_MIN);
        query_at(COORD_ONE, COORD_ONE);
        query_at(17'h1FFFF, 17'd70000);
        send_write(12'hFFF, pick_value());
        query_at(17'd32768, 17'd16384);
        query_at(17'd65535, 17'd49152);
        query_at(17'd16384, COORD_ONE);
    endtask

    // Main sequence: reset, directed requests, then one phase per shape
    initial
    begin : stimulus
        int dims;
        int divs;
        lattice_check = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_checks();
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 10)
            begin
                dims = SHAPE_DIMS[p];
                divs = SHAPE_DIVS[p];
            end
            else
            begin
                dims = $urandom_range(0, 7);
                divs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 9);
            end
            steady_flow = (p % 4 == 1);
            reshape(dims, divs, p == 2);
            // receiver holds off while requests keep coming
            if (p == 3 || p == 12)
                pressure_asked++;
            random_traffic(RANDOM_OPS_PER_PHASE);
        end
        settle();
        repeat (120) @(negedge clk);
        $display("Ran %0d queries (%0d over table size, %0d clamped) and %0d lattice writes,",
                 lattice_check.queries_seen, lattice_check.range_errors,
                 lattice_check.saturations, lattice_check.writes_seen);
        $display("across %0d register settings with random idles and %0d long result holds.",
                 settings_used, pressure_done);
        if (lattice_check.mismatches == 0 && lattice_check.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lmi_pkg.sv
rtl/lmi_ram.sv
rtl/lmi_datapath.sv
rtl/lmi_ctrl.sv
rtl/lattice_multilinear_interpolator_top.sv
test/tb_lattice_multilinear_interpolator_top.sv
